// ===== rtl/aabbcp_pkg.sv =====
// Shared constants and types for the box collide-and-push-out core.
`timescale 1ns / 1ps

package aabbcp_pkg;

  // Half extents are unsigned Q14.8 at a fixed width
  localparam int HALF_W = 22;

  // Default coordinate width, signed Q16.8
  localparam int COORD_W_DEF = 24;

  // Configuration register index
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_HALF_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_HALF_H = 2'd1;

  // Axis the collider was moved along
  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2
  } axis_e;

endpackage

// ===== rtl/aabbcp_sat.sv =====
// Signed saturation from a wide value down to a narrower signed range.
`timescale 1ns / 1ps

module aabbcp_sat #(
  parameter int IN_W  = 27,
  parameter int OUT_W = 24
) (
  input  logic signed [IN_W-1:0]  val_i,
  output logic signed [OUT_W-1:0] sat_o
);

  logic [IN_W-OUT_W:0] top_bits;
  logic                fits;

  // The value fits when every bit above the result sign matches it
  assign top_bits = val_i[IN_W-1:OUT_W-1];
  assign fits     = (top_bits == '0) || (top_bits == '1);

  // Clamp to the most negative or most positive code on overflow
  always_comb begin
    if (fits) begin
      sat_o = val_i[OUT_W-1:0];
    end else if (val_i[IN_W-1]) begin
      sat_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_o = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/aabb_collide_and_push_out_core.sv =====
// Top level of the box collide-and-push-out core: four-stage pipeline.
`timescale 1ns / 1ps

// Takes one box-pair request per clock and returns one result per request,
// marked by done_o for a single cycle. A request passes through the four
// register stages (offset, overlap test, push and axis choice, add and
// saturate); busy stays low because every stage advances each cycle, and
// results are not held, so the receiver must take done_o when it comes. The
// user must write collider half sizes through the cfg port only while no
// request is in flight; the block itself does not enforce this.
module aabb_collide_and_push_out_core
  import aabbcp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [HALF_W-1:0]             cfg_wdata_i,
  // Request
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] self_x_i,
  input  logic signed [COORD_WIDTH-1:0] self_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_y_i,
  input  logic [HALF_W-1:0]             box_half_w_i,
  input  logic [HALF_W-1:0]             box_half_h_i,
  // Result
  output logic                          done_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] new_x_o,
  output logic signed [COORD_WIDTH-1:0] new_y_o,
  output logic signed [COORD_WIDTH-1:0] push_x_o,
  output logic signed [COORD_WIDTH-1:0] push_y_o,
  output logic [1:0]                    moved_axis_o
);

  localparam int CW = COORD_WIDTH;
  // Width of centre offset magnitudes and summed half extents
  localparam int UW = (CW + 1 > HALF_W + 1) ? CW + 1 : HALF_W + 1;

  // Configuration registers
  logic [HALF_W-1:0] self_hw_q, self_hh_q;

  // Stage 1: offsets and summed half extents
  logic                 v1_q;
  logic signed [CW:0]   dx_q1, dy_q1;
  logic signed [CW-1:0] sx_q1, sy_q1;
  logic [HALF_W-1:0]    bhw_q1, bhh_q1;
  logic [HALF_W:0]      minx_q1, miny_q1;

  // Stage 2: magnitudes and overlap tests
  logic                 v2_q;
  logic [CW:0]          adx_d, ady_d, adx_q2, ady_q2;
  logic                 negx_q2, negy_q2, hit_q2, xin_q2, yin_q2;
  logic                 hit_d, xin_d, yin_d;
  logic signed [CW-1:0] sx_q2, sy_q2;
  logic [HALF_W-1:0]    bhw_q2, bhh_q2;
  logic [HALF_W:0]      minx_q2, miny_q2;

  // Stage 3: push vector and axis choice
  logic                 v3_q;
  logic signed [UW:0]   px_d, py_d, px_q3, py_q3;
  logic                 ex_lt_ey;
  axis_e                axis_d, axis_q3;
  logic                 hit_q3;
  logic signed [CW-1:0] sx_q3, sy_q3;

  // Stage 4: moved position and saturation
  logic signed [UW+1:0] sum_x, sum_y;
  logic signed [CW-1:0] sum_x_sat, sum_y_sat, px_sat, py_sat;

  // No stage ever waits, so a request is always taken
  assign busy = 1'b0;

  // Write the collider half sizes; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_hw_q <= '0;
      self_hh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SELF_HALF_W: self_hw_q <= cfg_wdata_i;
        CFG_SELF_HALF_H: self_hh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid bits advance one stage per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= start && !busy;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_o <= v3_q;
    end
  end

  // Stage 1: take box minus collider offsets and the overlap limits
  always_ff @(posedge clk_i) begin
    dx_q1   <= (CW+1)'(box_x_i) - (CW+1)'(self_x_i);
    dy_q1   <= (CW+1)'(box_y_i) - (CW+1)'(self_y_i);
    sx_q1   <= self_x_i;
    sy_q1   <= self_y_i;
    bhw_q1  <= box_half_w_i;
    bhh_q1  <= box_half_h_i;
    minx_q1 <= (HALF_W+1)'(self_hw_q) + (HALF_W+1)'(box_half_w_i);
    miny_q1 <= (HALF_W+1)'(self_hh_q) + (HALF_W+1)'(box_half_h_i);
  end

  // Stage 2: offset magnitudes and strict overlap compares
  always_comb begin
    adx_d = dx_q1[CW] ? $unsigned(-dx_q1) : $unsigned(dx_q1);
    ady_d = dy_q1[CW] ? $unsigned(-dy_q1) : $unsigned(dy_q1);
    hit_d = (UW'(adx_d) < UW'(minx_q1)) && (UW'(ady_d) < UW'(miny_q1));
    xin_d = UW'(adx_d) < UW'(bhw_q1);
    yin_d = UW'(ady_d) < UW'(bhh_q1);
  end

  always_ff @(posedge clk_i) begin
    adx_q2  <= adx_d;
    ady_q2  <= ady_d;
    negx_q2 <= dx_q1[CW];
    negy_q2 <= dy_q1[CW];
    hit_q2  <= hit_d;
    xin_q2  <= xin_d;
    yin_q2  <= yin_d;
    sx_q2   <= sx_q1;
    sy_q2   <= sy_q1;
    bhw_q2  <= bhw_q1;
    bhh_q2  <= bhh_q1;
    minx_q2 <= minx_q1;
    miny_q2 <= miny_q1;
  end

  // Stage 3: push points away from the box; a zero offset pushes negative
  always_comb begin
    px_d = negx_q2 ? $signed((UW+1)'(minx_q2) - (UW+1)'(adx_q2))
                   : $signed((UW+1)'(adx_q2) - (UW+1)'(minx_q2));
    py_d = negy_q2 ? $signed((UW+1)'(miny_q2) - (UW+1)'(ady_q2))
                   : $signed((UW+1)'(ady_q2) - (UW+1)'(miny_q2));
    // Edge distances compared without forming them: bhw-adx < bhh-ady
    ex_lt_ey = ((UW+1)'(bhw_q2) + (UW+1)'(ady_q2)) <
               ((UW+1)'(bhh_q2) + (UW+1)'(adx_q2));
    if (!hit_q2) begin
      axis_d = AXIS_NONE;
    end else if (xin_q2 && yin_q2) begin
      axis_d = ex_lt_ey ? AXIS_X : AXIS_Y;
    end else if (yin_q2) begin
      axis_d = AXIS_X;
    end else begin
      axis_d = AXIS_Y;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q3   <= px_d;
    py_q3   <= py_d;
    axis_q3 <= axis_d;
    hit_q3  <= hit_q2;
    sx_q3   <= sx_q2;
    sy_q3   <= sy_q2;
  end

  // Stage 4: apply the unsaturated push, then clamp everything
  assign sum_x = (UW+2)'(sx_q3) + (UW+2)'(px_q3);
  assign sum_y = (UW+2)'(sy_q3) + (UW+2)'(py_q3);

  aabbcp_sat #(.IN_W(UW+2), .OUT_W(CW)) u_sat_nx (.val_i(sum_x), .sat_o(sum_x_sat));
  aabbcp_sat #(.IN_W(UW+2), .OUT_W(CW)) u_sat_ny (.val_i(sum_y), .sat_o(sum_y_sat));
  aabbcp_sat #(.IN_W(UW+1), .OUT_W(CW)) u_sat_px (.val_i(px_q3), .sat_o(px_sat));
  aabbcp_sat #(.IN_W(UW+1), .OUT_W(CW)) u_sat_py (.val_i(py_q3), .sat_o(py_sat));

  // Result register; a miss leaves the collider where it was
  always_ff @(posedge clk_i) begin
    hit_o        <= hit_q3;
    new_x_o      <= (axis_q3 == AXIS_X) ? sum_x_sat : sx_q3;
    new_y_o      <= (axis_q3 == AXIS_Y) ? sum_y_sat : sy_q3;
    push_x_o     <= hit_q3 ? px_sat : '0;
    push_y_o     <= hit_q3 ? py_sat : '0;
    moved_axis_o <= axis_q3;
  end

endmodule

// ===== rtl/aabbcp_chk.sv =====
// Port-level checks for the collide-and-push-out core, bound to the top level.
`timescale 1ns / 1ps

module aabbcp_chk
  import aabbcp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] self_x_i,
  input logic signed [COORD_WIDTH-1:0] self_y_i,
  input logic                          done_o,
  input logic                          hit_o,
  input logic signed [COORD_WIDTH-1:0] new_x_o,
  input logic signed [COORD_WIDTH-1:0] new_y_o,
  input logic signed [COORD_WIDTH-1:0] push_x_o,
  input logic signed [COORD_WIDTH-1:0] push_y_o,
  input logic [1:0]                    moved_axis_o
);

  // Every accepted request yields a result
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("accepted request produced no result");

  // No result appears without an earlier accepted request
  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 4))
    else $error("result without a request");

  // A miss leaves the collider in place with no push
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (push_x_o == '0 && push_y_o == '0 &&
      moved_axis_o == AXIS_NONE && new_x_o == $past(self_x_i, 4) &&
      new_y_o == $past(self_y_i, 4)))
    else $error("miss result is not neutral");

  // A hit moves along exactly one axis and keeps the other coordinate
  a_hit_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (push_x_o != '0 && push_y_o != '0 &&
      ((moved_axis_o == AXIS_X && new_y_o == $past(self_y_i, 4)) ||
       (moved_axis_o == AXIS_Y && new_x_o == $past(self_x_i, 4)))))
    else $error("hit result moved on the wrong axis");

endmodule

bind aabb_collide_and_push_out_core aabbcp_chk #(
  .COORD_WIDTH(COORD_WIDTH)
) u_aabbcp_chk (.*);

// ===== dv/aabb_collide_and_push_out_core_tb.sv =====
// Self-checking testbench for the box collide-and-push-out core.
`timescale 1ns / 1ps

module aabb_collide_and_push_out_core_tb;
  import aabbcp_pkg::*;

  localparam int CW = COORD_W_DEF;
  localparam longint C_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint C_MIN = -C_MAX - 1;
  localparam longint H_MAX = (longint'(1) <<< HALF_W) - 1;
  localparam int LATENCY = 4;
  localparam int DRAIN_LIMIT = 200;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 108;
  localparam int PRINT_CAP = 40;
  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [HALF_W-1:0] half_t;

  typedef struct {
    coord_t self_x, self_y, box_x, box_y;
    half_t  half_w, half_h;
  } box_pair_t;

  typedef struct {
    logic   hit;
    coord_t new_x, new_y, push_x, push_y;
    axis_e  axis;
  } push_out_t;

  typedef struct {
    half_t     own_w, own_h;
    box_pair_t pair;
    bit        typed;
    push_out_t want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_SELF_HALF_W;
  half_t                cfg_wdata_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  coord_t               self_x_i = '0;
  coord_t               self_y_i = '0;
  coord_t               box_x_i = '0;
  coord_t               box_y_i = '0;
  half_t                box_half_w_i = '0;
  half_t                box_half_h_i = '0;
  logic                 done_o;
  logic                 hit_o;
  coord_t               new_x_o, new_y_o, push_x_o, push_y_o;
  logic [1:0]           moved_axis_o;

  // Collider half sizes as the block should hold them
  half_t     own_half_w = '0;
  half_t     own_half_h = '0;
  push_out_t pending_moves[$];
  dir_row_t  dir_rows[$];
  int        errors = 0;
  int        burst_left = 0;

  aabb_collide_and_push_out_core #(
    .COORD_WIDTH(CW)
  ) u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report(string what, longint got, longint want);
    if (errors < PRINT_CAP) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  function automatic longint clamp_coord(longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  // Overlap test, push vector and single-axis move for one request
  function automatic push_out_t resolve_push_out(box_pair_t p);
    push_out_t r;
    longint    dx, dy, adx, ady, min_x, min_y, px, py;
    bit        x_in, y_in;
    dx = longint'(p.box_x) - longint'(p.self_x);
    dy = longint'(p.box_y) - longint'(p.self_y);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    min_x = longint'(own_half_w) + longint'(p.half_w);
    min_y = longint'(own_half_h) + longint'(p.half_h);
    r.hit = (adx < min_x) && (ady < min_y);
    r.new_x = p.self_x;
    r.new_y = p.self_y;
    r.push_x = '0;
    r.push_y = '0;
    r.axis = AXIS_NONE;
    if (r.hit) begin
      x_in = adx < longint'(p.half_w);
      y_in = ady < longint'(p.half_h);
      // a zero offset pushes toward the negative side
      px = (dx < 0) ? (min_x - adx) : -(min_x - adx);
      py = (dy < 0) ? (min_y - ady) : -(min_y - ady);
      if (x_in && y_in) begin
        r.axis = ((longint'(p.half_w) - adx) < (longint'(p.half_h) - ady)) ? AXIS_X : AXIS_Y;
      end else if (y_in) begin
        r.axis = AXIS_X;
      end else begin
        r.axis = AXIS_Y;
      end
      // add the unsaturated push, then saturate
      if (r.axis == AXIS_X) begin
        r.new_x = coord_t'(clamp_coord(longint'(p.self_x) + px));
      end else begin
        r.new_y = coord_t'(clamp_coord(longint'(p.self_y) + py));
      end
      r.push_x = coord_t'(clamp_coord(px));
      r.push_y = coord_t'(clamp_coord(py));
    end
    return r;
  endfunction

  function automatic box_pair_t pair_of(longint sx, longint sy, longint bx, longint by,
                                        longint hw, longint hh);
    box_pair_t p;
    p.self_x = coord_t'(sx);
    p.self_y = coord_t'(sy);
    p.box_x = coord_t'(bx);
    p.box_y = coord_t'(by);
    p.half_w = half_t'(hw);
    p.half_h = half_t'(hh);
    return p;
  endfunction

  function automatic push_out_t outcome(logic hit, longint nx, longint ny, longint px,
                                        longint py, axis_e axis);
    push_out_t r;
    r.hit = hit;
    r.new_x = coord_t'(nx);
    r.new_y = coord_t'(ny);
    r.push_x = coord_t'(px);
    r.push_y = coord_t'(py);
    r.axis = axis;
    return r;
  endfunction

  function automatic push_out_t no_hit(box_pair_t p);
    return outcome(1'b0, p.self_x, p.self_y, 0, 0, AXIS_NONE);
  endfunction

  task automatic add_row(longint w, longint h, box_pair_t p);
    dir_row_t row;
    row.own_w = half_t'(w);
    row.own_h = half_t'(h);
    row.pair = p;
    row.typed = 1'b0;
    row.want = no_hit(p);
    dir_rows.push_back(row);
  endtask

  task automatic add_typed(longint w, longint h, box_pair_t p, push_out_t want);
    dir_row_t row;
    row.own_w = half_t'(w);
    row.own_h = half_t'(h);
    row.pair = p;
    row.typed = 1'b1;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic longint with_sign(longint mag);
    return ($urandom_range(0, 1) == 1) ? -mag : mag;
  endfunction

  function automatic longint signed_offset(longint reach);
    longint mag;
    mag = longint'($urandom_range(0, 32'(reach)));
    return with_sign(mag);
  endfunction

  // Half size with a random number of significant bits, zero and full range included
  function automatic half_t pick_half();
    int k;
    k = $urandom_range(0, HALF_W);
    return half_t'($urandom_range(0, (32'd1 << k) - 1));
  endfunction

  function automatic longint place(longint base, longint off);
    longint b;
    b = base + off;
    if (b > C_MAX || b < C_MIN) b = base - off;
    return clamp_coord(b);
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int        mode;
    longint    reach_x, reach_y, sx, sy, dx, dy;
    mode = $urandom_range(0, 99);
    p.half_w = pick_half();
    p.half_h = pick_half();
    reach_x = longint'(own_half_w) + longint'(p.half_w);
    reach_y = longint'(own_half_h) + longint'(p.half_h);
    sx = signed_offset(C_MAX / 2);
    sy = signed_offset(C_MAX / 2);
    dx = signed_offset(reach_x + reach_x / 4 + 1);
    dy = signed_offset(reach_y + reach_y / 4 + 1);
    // any bits at all, mostly far apart
    if (mode >= 90) begin
      p.self_x = coord_t'($urandom);
      p.self_y = coord_t'($urandom);
      p.box_x = coord_t'($urandom);
      p.box_y = coord_t'($urandom);
      p.half_w = half_t'($urandom);
      p.half_h = half_t'($urandom);
      return p;
    end
    if (mode < 15) begin
      // sit on the overlap edge or one step inside it
      if ($urandom_range(0, 1) == 1) begin
        dx = with_sign(reach_x - longint'($urandom_range(0, 1)));
      end else begin
        dy = with_sign(reach_y - longint'($urandom_range(0, 1)));
      end
    end else if (mode < 25) begin
      // equal margins to the box edges on both axes
      dx = longint'($urandom_range(0, 32'(p.half_w)));
      dy = longint'(p.half_h) - longint'(p.half_w) + dx;
      if (dy < 0) dy = 0;
      dx = with_sign(dx);
      dy = with_sign(dy);
    end else if (mode < 40) begin
      // collider near the coordinate limits
      sx = longint'($urandom_range(0, 255));
      sy = longint'($urandom_range(0, 255));
      sx = ($urandom_range(0, 1) == 1) ? C_MAX - sx : C_MIN + sx;
      sy = ($urandom_range(0, 1) == 1) ? C_MAX - sy : C_MIN + sy;
    end
    p.self_x = coord_t'(sx);
    p.self_y = coord_t'(sy);
    p.box_x = coord_t'(place(sx, dx));
    p.box_y = coord_t'(place(sy, dy));
    return p;
  endfunction

  // Hold the sender and wait for every outstanding result
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_moves.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_moves.size() != 0) begin
      report("results never returned", 0, pending_moves.size());
      pending_moves.delete();
    end
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, half_t data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SELF_HALF_W: own_half_w = data;
      CFG_SELF_HALF_H: own_half_h = data;
      default: ;
    endcase
  endtask

  // Reprogram the collider size while idle; a spare index write must not land
  task automatic set_sizes(half_t w, half_t h);
    drain();
    cfg_write(CFG_SELF_HALF_W, w);
    cfg_write(($urandom_range(0, 1) == 1) ? CFG_SPARE_2 : CFG_SPARE_3, half_t'($urandom));
    cfg_write(CFG_SELF_HALF_H, h);
    cfg_we_i <= 1'b0;
  endtask

  // Present one request, wait for acceptance, then maybe open a gap
  task automatic issue(box_pair_t p, push_out_t want);
    int gap;
    self_x_i <= p.self_x;
    self_y_i <= p.self_y;
    box_x_i <= p.box_x;
    box_y_i <= p.box_y;
    box_half_w_i <= p.half_w;
    box_half_h_i <= p.half_h;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_moves.push_back(want);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Check each result against the oldest outstanding request
  always @(posedge clk_i) begin
    push_out_t want;
    if (rst_ni && done_o) begin
      if (pending_moves.size() == 0) begin
        report("result with no request", 1, 0);
      end else begin
        want = pending_moves.pop_front();
        if (hit_o !== want.hit) report("hit", hit_o, want.hit);
        if (new_x_o !== want.new_x) report("new_x", new_x_o, want.new_x);
        if (new_y_o !== want.new_y) report("new_y", new_y_o, want.new_y);
        if (push_x_o !== want.push_x) report("push_x", push_x_o, want.push_x);
        if (push_y_o !== want.push_y) report("push_y", push_y_o, want.push_y);
        if (moved_axis_o !== want.axis) report("moved_axis", moved_axis_o, want.axis);
      end
    end
  end

  initial begin
    box_pair_t p;
    push_out_t want;
    half_t     w, h;

    // Directed requests; the first rows run on the reset sizes
    p = pair_of(0, 0, 0, 0, 0, 0);
    add_typed(0, 0, p, no_hit(p));
    p = pair_of(C_MAX, C_MAX, C_MIN, C_MIN, H_MAX, H_MAX);
    add_typed(0, 0, p, no_hit(p));
    p = pair_of(C_MIN, C_MIN, C_MAX, C_MAX, H_MAX, H_MAX);
    add_typed(0, 0, p, no_hit(p));
    p = pair_of(0, 0, 1, 1, 2, 2);
    add_row(0, 0, p);
    // centres coincide: push negative on both axes, x margin is smaller
    p = pair_of(0, 0, 0, 0, 256, 512);
    add_typed(256, 256, p, outcome(1'b1, -512, 0, -512, -768, AXIS_X));
    p = pair_of(0, 0, 512, 0, 256, 256);
    add_typed(256, 256, p, no_hit(p));
    p = pair_of(0, 0, 511, 0, 256, 256);
    add_row(256, 256, p);
    p = pair_of(0, 0, 0, -512, 256, 256);
    add_typed(256, 256, p, no_hit(p));
    p = pair_of(0, 0, 0, -511, 256, 256);
    add_row(256, 256, p);
    p = pair_of(0, 0, 300, 10, 256, 256);
    add_row(256, 256, p);
    p = pair_of(0, 0, 10, 300, 256, 256);
    add_row(256, 256, p);
    p = pair_of(0, 0, 300, 300, 256, 256);
    add_row(256, 256, p);
    p = pair_of(0, 0, 10, 10, 256, 256);
    add_row(256, 256, p);
    p = pair_of(0, 0, 200, 10, 256, 256);
    add_row(256, 256, p);
    p = pair_of(1000, -1000, 800, -990, 256, 256);
    add_row(256, 256, p);
    // largest sizes: new position runs into the coordinate limits
    p = pair_of(C_MAX, 0, C_MAX - 1, 0, H_MAX, H_MAX);
    add_typed(H_MAX, H_MAX, p, outcome(1'b1, C_MAX, 0, C_MAX - 2, -(C_MAX - 1), AXIS_X));
    p = pair_of(C_MIN, 0, C_MIN + 1, 0, H_MAX, H_MAX);
    add_row(H_MAX, H_MAX, p);
    p = pair_of(0, C_MAX, 0, C_MAX - 1, H_MAX, H_MAX);
    add_row(H_MAX, H_MAX, p);
    p = pair_of(0, C_MIN, 0, C_MIN + 1, H_MAX, H_MAX);
    add_row(H_MAX, H_MAX, p);
    p = pair_of(C_MIN, C_MIN, C_MAX, C_MAX, H_MAX, H_MAX);
    add_typed(H_MAX, H_MAX, p, no_hit(p));
    p = pair_of(5, 5, 5, 5, 0, 0);
    add_typed(H_MAX, 0, p, no_hit(p));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].own_w != own_half_w || dir_rows[i].own_h != own_half_h) begin
        set_sizes(dir_rows[i].own_w, dir_rows[i].own_h);
      end
      if (dir_rows[i].typed) want = dir_rows[i].want;
      else want = resolve_push_out(dir_rows[i].pair);
      issue(dir_rows[i].pair, want);
    end

    // Random requests in phases, each of which sets its collider size
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 5)
        0: begin
          w = '0;
          h = '0;
        end
        1: begin
          w = half_t'(H_MAX);
          h = half_t'(H_MAX);
        end
        2: begin
          w = '0;
          h = half_t'(H_MAX);
        end
        3: begin
          w = half_t'($urandom);
          h = half_t'($urandom);
        end
        default: begin
          w = pick_half();
          h = pick_half();
        end
      endcase
      set_sizes(w, h);
      repeat (PHASE_ITEMS) begin
        p = random_pair();
        issue(p, resolve_push_out(p));
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("aabb_collide_and_push_out_core: match");
    end else begin
      $display("aabb_collide_and_push_out_core: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #5_000_000;
    $display("aabb_collide_and_push_out_core: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aabbcp_pkg.sv
rtl/aabbcp_sat.sv
rtl/aabb_collide_and_push_out_core.sv
rtl/aabbcp_chk.sv
dv/aabb_collide_and_push_out_core_tb.sv
